// ===== rtl/gbm_pkg.sv =====
// Package for the greedy b-matching filter.
// Field widths, reset constants and the count store read bundle.
// No dependencies.
package gbm_pkg;

    localparam int NODE_W        = 10;
    localparam int WEIGHT_W      = 32;
    localparam int SUM_W         = 48;
    localparam int CNT_W         = 8;
    localparam int IDX_EXT_W     = 17;
    localparam int NODE_COUNT_DEF = 1024;
    localparam int IN_TDATA_W    = 56;
    localparam int OUT_TDATA_W   = 48;

    localparam logic [CNT_W-1:0] B_LIMIT_RST = 8'd1;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        t_cnt b0_row;
        t_cnt b0_col;
        t_cnt b1_row;
        t_cnt b1_col;
    } t_cnt_rd;

endpackage

// ===== rtl/gbm_count_store.sv =====
// Per-node count store: two XOR banks, each one write and two reads per cycle.
// A node count is bank0 ^ bank1; clears both banks after reset.
// Depends on gbm_pkg.
module gbm_count_store import gbm_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int AW         = $clog2(NODE_COUNT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_row,
    input  logic [AW-1:0] i_rd_col,
    output t_cnt_rd       o_rd,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_row,
    input  logic [AW-1:0] i_wr_col,
    input  t_cnt          i_wd0,
    input  t_cnt          i_wd1,
    output logic          o_busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);

    t_cnt r_bank0 [NODE_COUNT];
    t_cnt r_bank1 [NODE_COUNT];

    logic          r_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_bank0[r_clr_addr] <= '0;
            r_bank1[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_bank0[i_wr_row] <= i_wd0;
            r_bank1[i_wr_col] <= i_wd1;
        end
        if (i_rd_en) begin
            o_rd.b0_row <= r_bank0[i_rd_row];
            o_rd.b0_col <= r_bank0[i_rd_col];
            o_rd.b1_row <= r_bank1[i_rd_row];
            o_rd.b1_col <= r_bank1[i_rd_col];
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== rtl/greedy_b_matching_filter.sv =====
// Greedy b-matching acceptance filter: one result transfer per edge transfer.
// An edge transfer passes through the s1 stage and the output register to the master side.
// Throughput: one edge per cycle while m_axis_tready is high and no clear runs; counts are read
// at transfer, updated from the s1 stage with forwarding from the previous update into the count store.
// Reset: synchronous; a clearing pass over all NODE_COUNT addresses holds s_axis_tready low.
// Depends on gbm_pkg and gbm_count_store.
module greedy_b_matching_filter import gbm_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CNT_W-1:0]       i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // row_node, column_node, edge_weight
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // total_weight
    output logic                   m_axis_tuser,  // accepted
    output logic                   m_axis_tlast
);

    localparam int AW = $clog2(NODE_COUNT);

    logic [NODE_W-1:0]   in_row;
    logic [NODE_W-1:0]   in_col;
    logic [WEIGHT_W-1:0] in_weight;
    logic [IDX_EXT_W-1:0] row_ext;
    logic [IDX_EXT_W-1:0] col_ext;
    logic                in_ok;
    logic                in_xfer;
    logic                busy;

    logic [CNT_W-1:0]    r_b_limit;

    logic                r_s1_valid;
    logic [AW-1:0]       r_s1_row;
    logic [AW-1:0]       r_s1_col;
    logic                r_s1_ok;
    logic [WEIGHT_W-1:0] r_s1_weight;
    logic                r_s1_last;

    logic                r_out_valid;
    logic                r_out_take;
    logic [SUM_W-1:0]    r_out_sum;
    logic                r_out_last;

    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;

    logic                r_prev_wr;
    logic [AW-1:0]       r_prev_row;
    logic [AW-1:0]       r_prev_col;
    t_cnt                r_prev_wd0;
    t_cnt                r_prev_wd1;

    t_cnt_rd             rd;
    t_cnt                b0_row;
    t_cnt                b1_row;
    t_cnt                b0_col;
    t_cnt                b1_col;
    t_cnt                cnt_row;
    t_cnt                cnt_col;
    t_cnt                wd0;
    t_cnt                wd1;
    logic                take;
    logic                s1_adv;
    logic                we;

    assign in_row    = s_axis_tdata[NODE_W-1:0];
    assign in_col    = s_axis_tdata[2*NODE_W-1:NODE_W];
    assign in_weight = s_axis_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];
    assign row_ext   = {{(IDX_EXT_W-NODE_W){1'b0}}, in_row};
    assign col_ext   = {{(IDX_EXT_W-NODE_W){1'b0}}, in_col};
    assign in_ok     = (in_row != in_col)
                     && (row_ext < IDX_EXT_W'(NODE_COUNT))
                     && (col_ext < IDX_EXT_W'(NODE_COUNT));

    assign s1_adv        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !busy && (!r_s1_valid || s1_adv);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    gbm_count_store #(
        .NODE_COUNT (NODE_COUNT),
        .AW         (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_xfer),
        .i_rd_row (row_ext[AW-1:0]),
        .i_rd_col (col_ext[AW-1:0]),
        .o_rd     (rd),
        .i_we     (we),
        .i_wr_row (r_s1_row),
        .i_wr_col (r_s1_col),
        .i_wd0    (wd0),
        .i_wd1    (wd1),
        .o_busy   (busy)
    );

    // forward the previous update over the stale read data
    always_comb begin
        b0_row  = (r_prev_wr && r_s1_row == r_prev_row) ? r_prev_wd0 : rd.b0_row;
        b1_row  = (r_prev_wr && r_s1_row == r_prev_col) ? r_prev_wd1 : rd.b1_row;
        b0_col  = (r_prev_wr && r_s1_col == r_prev_row) ? r_prev_wd0 : rd.b0_col;
        b1_col  = (r_prev_wr && r_s1_col == r_prev_col) ? r_prev_wd1 : rd.b1_col;
        cnt_row = b0_row ^ b1_row;
        cnt_col = b0_col ^ b1_col;
        take    = r_s1_ok && (cnt_row < r_b_limit) && (cnt_col < r_b_limit);
        wd0     = (cnt_row + CNT_W'(1)) ^ b1_row;
        wd1     = (cnt_col + CNT_W'(1)) ^ b0_col;
        n_sum   = r_sum + {{(SUM_W-WEIGHT_W){r_s1_weight[WEIGHT_W-1]}}, r_s1_weight};
    end

    assign we = r_s1_valid && s1_adv && take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_limit   <= B_LIMIT_RST;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_prev_wr   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_b_limit <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (we) begin
                r_sum     <= n_sum;
                r_prev_wr <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_row    <= row_ext[AW-1:0];
            r_s1_col    <= col_ext[AW-1:0];
            r_s1_ok     <= in_ok;
            r_s1_weight <= in_weight;
            r_s1_last   <= s_axis_tlast;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_take <= take;
            r_out_sum  <= take ? n_sum : r_sum;
            r_out_last <= r_s1_last;
        end
        if (we) begin
            r_prev_row <= r_s1_row;
            r_prev_col <= r_s1_col;
            r_prev_wd0 <= wd0;
            r_prev_wd1 <= wd1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sum;
    assign m_axis_tuser  = r_out_take;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_no_xfer_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_axis_tready)
        else $error("edge transfer during count clear");

    a_write_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_s1_row != r_s1_col))
        else $error("count update on a self-loop");

    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !we) |=> $stable(r_sum))
        else $error("total changed without an accepted edge");
`endif

endmodule
